// ----- rtl/core/tss_pkg.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// tss_pkg
// Shared types, constants and exponential tables for the top-K softmax router.
// -----------------------------------------------------------------------------
package tss_pkg;

  localparam int unsigned SCORE_W = 16;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned SUM_W = 20;
  localparam int unsigned EXP_W = 17;
  localparam int unsigned DIV_W = 37;

  // register byte addresses
  localparam logic [1:0] REG_TOP_COUNT = 2'd0;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      last_score;
    logic                      row_active;
  } in_req_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  expert_index;
    logic [WEIGHT_W-1:0] weight;
    logic                found;
    logic                last_result;
  } out_req_t;

  // exp(-n), n integer part
  function automatic logic [EXP_W-1:0] exp_int(input logic [3:0] n);
    logic [EXP_W-1:0] v;
    case (n)
      4'd0: v = 17'd65536;
      4'd1: v = 17'd24109;
      4'd2: v = 17'd8869;
      4'd3: v = 17'd3263;
      4'd4: v = 17'd1200;
      4'd5: v = 17'd442;
      4'd6: v = 17'd162;
      4'd7: v = 17'd60;
      4'd8: v = 17'd22;
      4'd9: v = 17'd8;
      4'd10: v = 17'd3;
      4'd11: v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // exp(-h/16)
  function automatic logic [EXP_W-1:0] exp_high(input logic [3:0] h);
    logic [EXP_W-1:0] v;
    case (h)
      4'd0: v = 17'd65536;
      4'd1: v = 17'd61565;
      4'd2: v = 17'd57835;
      4'd3: v = 17'd54331;
      4'd4: v = 17'd51039;
      4'd5: v = 17'd47947;
      4'd6: v = 17'd45042;
      4'd7: v = 17'd42313;
      4'd8: v = 17'd39750;
      4'd9: v = 17'd37341;
      4'd10: v = 17'd35079;
      4'd11: v = 17'd32954;
      4'd12: v = 17'd30957;
      4'd13: v = 17'd29081;
      4'd14: v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

  // exp(-l/256)
  function automatic logic [EXP_W-1:0] exp_low(input logic [3:0] l);
    logic [EXP_W-1:0] v;
    case (l)
      4'd0: v = 17'd65536;
      4'd1: v = 17'd65280;
      4'd2: v = 17'd65026;
      4'd3: v = 17'd64772;
      4'd4: v = 17'd64520;
      4'd5: v = 17'd64268;
      4'd6: v = 17'd64018;
      4'd7: v = 17'd63768;
      4'd8: v = 17'd63520;
      4'd9: v = 17'd63272;
      4'd10: v = 17'd63025;
      4'd11: v = 17'd62780;
      4'd12: v = 17'd62535;
      4'd13: v = 17'd62291;
      4'd14: v = 17'd62048;
      default: v = 17'd61806;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/tss_div.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// tss_div
// Restoring divider, one quotient bit per cycle, saturated to 16 bits.
// -----------------------------------------------------------------------------
module tss_div (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic [tss_pkg::DIV_W-1:0]          numer,
  input  wire logic [tss_pkg::SUM_W-1:0]          denom,
  output logic                                    done,
  output logic [tss_pkg::WEIGHT_W-1:0]            quot
);

  localparam int unsigned CNT_W = $clog2(tss_pkg::DIV_W + 1);

  logic [tss_pkg::DIV_W-1:0] num_r;
  logic [tss_pkg::DIV_W-1:0] q_r;
  logic [tss_pkg::SUM_W-1:0] rem_r;
  logic [tss_pkg::SUM_W-1:0] den_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic [tss_pkg::SUM_W:0]   trial;
  logic [tss_pkg::SUM_W+1:0] diff;

  assign done = done_r;

  // one shift-subtract step
  always_comb begin
    trial = {rem_r, num_r[tss_pkg::DIV_W-1]};
    diff  = {1'b0, trial} - {2'b00, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(tss_pkg::DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor, so it fits the divisor width
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= numer;
      den_r <= denom;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[tss_pkg::DIV_W-2:0], 1'b0};
      if (!diff[tss_pkg::SUM_W+1]) begin
        rem_r <= diff[tss_pkg::SUM_W-1:0];
        q_r   <= {q_r[tss_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[tss_pkg::SUM_W-1:0];
        q_r   <= {q_r[tss_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  // saturate
  assign quot = (q_r[tss_pkg::DIV_W-1:tss_pkg::WEIGHT_W] != '0) ? '1
                : q_r[tss_pkg::WEIGHT_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/core/topk_select_softmax.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// topk_select_softmax
// Streaming top-K selector over router scores with softmax weights.
// -----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | input     | tss_pkg::in_req_t  (score, last_score, row_active)
//  out_    | output    | tss_pkg::out_req_t (expert_index, weight, found, last_result)
//  cfg_    | APB       | register 0 at byte 0: top_count
//
// Ranking: each score is inserted by walking the slot memory, one read and one
// write a cycle, with a scan and a wait step per compared slot and a shift and
// a write step per moved slot. At the end of a row a sum pass runs the exponent
// steps for each ranked slot, and each ranked result then takes the exponent
// steps, a serial division and an output step.
// Reset is synchronous and clears control state and the slot count; the slot
// memory needs no clearing since only the first `fill` slots are ever read.
// A stalled result holds; no request is taken outside the idle state.
module topk_select_softmax #(
  parameter int unsigned MAX_TOP = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tss_pkg::in_req_t   in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tss_pkg::out_req_t       out_data,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [1:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  localparam int unsigned AW = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
  localparam int unsigned FW = $clog2(MAX_TOP + 1);
  localparam int unsigned MAX_EXPERTS = 256;
  localparam int unsigned SEEN_W = 9;
  localparam int unsigned SW = tss_pkg::SCORE_W;
  localparam int unsigned IW = tss_pkg::INDEX_W;
  localparam int unsigned EW = tss_pkg::EXP_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_W, S_SHIFT, S_SHIFT_W, S_PLACE,
    S_SUM, S_SUM_W, S_EXP1, S_EXP2, S_DIV, S_OUT, S_CLEAR
  } state_t;

  // configuration
  logic [3:0] top_count_r;
  logic       cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr == tss_pkg::REG_TOP_COUNT);
  assign cfg_prdata = {28'd0, top_count_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_count_r <= 4'd4;
    end else if (cfg_wr) begin
      top_count_r <= cfg_pwdata[3:0];
    end
  end

  logic [FW-1:0] k_eff;
  always_comb begin
    if (top_count_r == 4'd0) k_eff = FW'(1);
    else if (32'(top_count_r) > MAX_TOP) k_eff = FW'(MAX_TOP);
    else k_eff = FW'(top_count_r);
  end

  // slot memory: score and index, one port each way
  logic [SW+IW-1:0] mem [MAX_TOP];
  logic             mem_we;
  logic [AW-1:0]    mem_wa, mem_ra;
  logic [SW+IW-1:0] mem_wd, mem_rd_r;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_r <= mem[mem_ra];
  end

  state_t               state_r;
  logic [FW-1:0]        fill_r;
  logic [FW-1:0]        pos_r;
  logic [FW-1:0]        k_r;
  logic [SEEN_W-1:0]    seen_r;
  logic signed [SW-1:0] s_r;
  logic [IW-1:0]        idx_r;
  logic                 last_r;
  logic signed [SW-1:0] max_r;
  logic [tss_pkg::SUM_W-1:0] sum_r;
  logic [21:0]          acc_r;
  logic [EW-1:0]        v_r;
  logic                 l_r;
  logic [FW-1:0]        oidx_r;
  logic                 div_start_r;
  tss_pkg::out_req_t    out_r;
  logic                 out_valid_r;
  logic [7:0]           hold_r;

  logic [tss_pkg::WEIGHT_W-1:0] quot;
  logic                          div_done;
  tss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .numer (tss_pkg::DIV_W'({v_r, 16'd0}) + tss_pkg::DIV_W'(sum_r >> 1)),
    .denom (sum_r),
    .done  (div_done),
    .quot  (quot)
  );

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  // exponential of d = max - score
  logic [16:0]     d_w;
  logic [2*EW-1:0] prod;
  logic [EW-1:0]   prod_rnd;
  logic signed [SW-1:0] rd_score;
  assign rd_score = mem_rd_r[SW+IW-1:IW];
  assign d_w = 17'(signed'({max_r[SW-1], max_r}) - signed'({rd_score[SW-1], rd_score}));

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_ra = '0;
    case (state_r)
      S_SCAN, S_SCAN_W: mem_ra = AW'(pos_r);
      S_SHIFT:   mem_ra = AW'(pos_r - 1'b1);
      S_SHIFT_W: begin
        mem_we = 1'b1;
        mem_wa = AW'(pos_r);
        mem_wd = mem_rd_r;
      end
      S_PLACE: begin
        mem_we = 1'b1;
        mem_wa = AW'(pos_r);
        mem_wd = {s_r, idx_r};
      end
      S_SUM, S_SUM_W, S_EXP1, S_EXP2, S_DIV, S_OUT: mem_ra = AW'(pos_r);
      default: ;
    endcase
  end

  logic [EW-1:0] exp_high_sel;
  assign exp_high_sel = (l_r ? tss_pkg::exp_low(hold_r[3:0])
                             : tss_pkg::exp_high(hold_r[7:4]));
  always_comb prod = v_r * exp_high_sel;
  assign prod_rnd = EW'((prod + 34'd32768) >> 16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      sum_r       <= '0;
    end else begin
      div_start_r <= 1'b0;
      // result register: load in the output state, drop once taken
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid) begin
          s_r    <= in_data.score;
          idx_r  <= seen_r[IW-1:0];
          last_r <= in_data.last_score;
          k_r    <= k_eff;
          pos_r  <= '0;
          if (in_data.row_active && 32'(seen_r) < MAX_EXPERTS) begin
            seen_r  <= seen_r + 1'b1;
            state_r <= S_SCAN;
          end else if (in_data.last_score && !in_data.row_active) begin
            state_r <= S_CLEAR;
          end else if (in_data.last_score) begin
            state_r <= S_SUM;
            acc_r   <= '0;
          end
        end
        // find insertion point
        S_SCAN: begin
          if (pos_r >= k_r) begin
            state_r <= last_r ? S_SUM : S_IDLE;
            pos_r   <= '0;
            acc_r   <= '0;
          end else if (pos_r >= fill_r) begin
            state_r <= S_PLACE;
          end else begin
            state_r <= S_SCAN_W;
          end
        end
        S_SCAN_W: begin
          if (s_r > rd_score) begin
            pos_r   <= (fill_r < k_r) ? fill_r : k_r - 1'b1;
            state_r <= S_SHIFT;
            oidx_r  <= pos_r;
          end else begin
            pos_r   <= pos_r + 1'b1;
            state_r <= S_SCAN;
          end
        end
        // move slots down one place
        S_SHIFT: begin
          if (pos_r == oidx_r) state_r <= S_PLACE;
          else state_r <= S_SHIFT_W;
        end
        S_SHIFT_W: begin
          pos_r   <= pos_r - 1'b1;
          state_r <= S_SHIFT;
        end
        S_PLACE: begin
          if (fill_r < k_r) fill_r <= fill_r + 1'b1;
          pos_r   <= '0;
          acc_r   <= '0;
          state_r <= last_r ? S_SUM : S_IDLE;
        end
        // sum of exponentials, slot 0 gives the max
        S_SUM: state_r <= S_SUM_W;
        S_SUM_W: begin
          if (pos_r == '0) max_r <= rd_score;
          state_r <= S_EXP1;
          hold_r  <= (pos_r == '0) ? 8'd0 : d_w[7:0];
          v_r     <= (pos_r == '0) ? 17'd65536 :
                     ((d_w[16:12] != 5'd0) ? '0 : tss_pkg::exp_int(d_w[11:8]));
          l_r     <= 1'b0;
        end
        S_EXP1: begin
          v_r     <= prod_rnd;
          l_r     <= 1'b1;
          state_r <= S_EXP2;
        end
        S_EXP2: begin
          v_r <= prod_rnd;
          if (acc_r[21]) begin
            // output pass: v ready, divide
            div_start_r <= 1'b1;
            state_r     <= S_DIV;
          end else if (pos_r + 1'b1 >= k_r || pos_r + 1'b1 >= fill_r) begin
            sum_r   <= tss_pkg::SUM_W'(acc_r + 22'(prod_rnd));
            acc_r   <= 22'h200000;
            pos_r   <= '0;
            state_r <= (fill_r == '0) ? S_OUT : S_SUM;
          end else begin
            acc_r   <= acc_r + 22'(prod_rnd);
            pos_r   <= pos_r + 1'b1;
            state_r <= S_SUM;
          end
        end
        S_DIV: if (div_done) begin
          state_r <= S_OUT;
        end
        // one result per slot
        S_OUT: if (!out_valid_r || !out_stall) begin
          out_r.found          <= (pos_r < fill_r);
          out_r.expert_index   <= (pos_r < fill_r) ? mem_rd_r[IW-1:0] : '0;
          out_r.weight         <= (pos_r < fill_r && sum_r != '0) ? quot : '0;
          out_r.last_result    <= (pos_r == k_r - 1'b1);
          if (pos_r == k_r - 1'b1) begin
            state_r <= S_CLEAR;
          end else begin
            pos_r   <= pos_r + 1'b1;
            state_r <= (pos_r + 1'b1 < fill_r) ? S_SUM : S_OUT;
          end
        end
        S_CLEAR: begin
          fill_r  <= '0;
          seen_r  <= '0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sim/topk_checker.sv -----
// -----------------------------------------------------------------------------
// topk_checker
// Watches the score and result channels of the top-K softmax router, predicts
// the ranked experts and their weights for every finished row, and compares
// each result field by field in order.
// -----------------------------------------------------------------------------
module topk_checker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire tss_pkg::in_req_t  in_data,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire tss_pkg::out_req_t out_data,
  input  wire logic [3:0]        top_count,
  output int                     fail_count,
  output int                     pending,
  output int                     rows_done,
  output int                     results_seen
);

  localparam int SLOTS = 8;
  localparam int ROW_LIMIT = 256;

  // ranking chain copy
  logic signed [15:0] rank_score [SLOTS];
  logic [7:0]         rank_index [SLOTS];
  logic               rank_valid [SLOTS];
  int                 seen_count;
  tss_pkg::out_req_t  expected_results [$];

  localparam int EI [16] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                             22, 8, 3, 1, 0, 0, 0, 0};
  localparam int EH [16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042,
                             42313, 39750, 37341, 35079, 32954, 30957, 29081,
                             27319, 25664};
  localparam int EL [16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018,
                             63768, 63520, 63272, 63025, 62780, 62535, 62291,
                             62048, 61806};

  function automatic longint exp_of_gap(longint d);
    longint v;
    if ((d >> 8) >= 16) return 0;
    v = EI[d >> 8];
    v = (v * EH[(d >> 4) & 15] + 32768) >> 16;
    v = (v * EL[d & 15] + 32768) >> 16;
    return v;
  endfunction

  function automatic int effective_k();
    int k;
    k = top_count;
    if (k < 1) k = 1;
    if (k > SLOTS) k = SLOTS;
    return k;
  endfunction

  task automatic clear_chain();
    for (int i = 0; i < SLOTS; i++) begin
      rank_score[i] = '0;
      rank_index[i] = '0;
      rank_valid[i] = 1'b0;
    end
    seen_count = 0;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // rank one score, emit predicted results at row end
  task automatic absorb_request(tss_pkg::in_req_t r);
    int k, p;
    longint e [SLOTS];
    longint total, w;
    tss_pkg::out_req_t o;
    k = effective_k();
    if (r.row_active && seen_count < ROW_LIMIT) begin
      p = k;
      for (int i = 0; i < k; i++)
        if (!rank_valid[i] || r.score > rank_score[i]) begin
          p = i;
          break;
        end
      if (p < k) begin
        for (int j = k - 1; j > p; j--) begin
          rank_score[j] = rank_score[j-1];
          rank_index[j] = rank_index[j-1];
          rank_valid[j] = rank_valid[j-1];
        end
        rank_score[p] = r.score;
        rank_index[p] = seen_count[7:0];
        rank_valid[p] = 1'b1;
      end
      seen_count++;
    end
    if (!r.last_score) return;
    if (!r.row_active) begin
      clear_chain();
      return;
    end
    total = 0;
    for (int i = 0; i < k; i++) begin
      e[i] = 0;
      if (rank_valid[i] && rank_valid[0]) begin
        e[i] = exp_of_gap(longint'(rank_score[0]) - longint'(rank_score[i]));
        total += e[i];
      end
    end
    for (int i = 0; i < k; i++) begin
      w = 0;
      if (rank_valid[i] && total != 0) begin
        w = (e[i] * 65536 + total / 2) / total;
        if (w > 65535) w = 65535;
      end
      o.expert_index = rank_valid[i] ? rank_index[i] : '0;
      o.weight = w[15:0];
      o.found = rank_valid[i];
      o.last_result = (i == k - 1);
      expected_results.push_back(o);
    end
    pending = expected_results.size();
    rows_done++;
    clear_chain();
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    rows_done = 0;
    results_seen = 0;
    clear_chain();
  end

  // watch both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) absorb_request(in_data);
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result count", results_seen, results_seen - 1);
        end else begin
          tss_pkg::out_req_t want;
          want = expected_results.pop_front();
          pending = expected_results.size();
          if (out_data.expert_index !== want.expert_index)
            report_mismatch("expert_index", out_data.expert_index, want.expert_index);
          if (out_data.weight !== want.weight)
            report_mismatch("weight", out_data.weight, want.weight);
          if (out_data.found !== want.found)
            report_mismatch("found", out_data.found, want.found);
          if (out_data.last_result !== want.last_result)
            report_mismatch("last_result", out_data.last_result, want.last_result);
        end
      end
    end
  end

endmodule

// ----- sim/tb.sv -----
// -----------------------------------------------------------------------------
// tb
// Drives rows of router scores through the top-K softmax router under several
// K settings with random gaps and stalls; the checker judges every result.
// -----------------------------------------------------------------------------
module tb;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  tss_pkg::in_req_t in_data;
  logic out_valid;
  logic out_stall;
  tss_pkg::out_req_t out_data;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;
  logic [3:0] k_model;
  int fail_count, pending, rows_done, results_seen;
  int sent_count;

  topk_select_softmax dut (.*);

  topk_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .top_count(k_model), .fail_count, .pending, .rows_done,
    .results_seen
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(3, 30);
  endfunction

  // result side stalls at random, with calm stretches
  initial begin
    out_stall = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat (gap_len() + 1) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_top_count(logic [3:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= tss_pkg::REG_TOP_COUNT;
    cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk iff cfg_pready);
    k_model = value;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic send_score(logic signed [15:0] s, logic last, logic act);
    repeat (gap_len()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{score: s, last_score: last, row_active: act};
    @(posedge clk iff !in_stall);
    sent_count++;
  endtask

  task automatic send_row(int n, int spread, bit act);
    logic signed [15:0] base;
    base = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      logic signed [15:0] s;
      s = (spread == 0) ? 16'($urandom) : base + 16'($urandom_range(0, spread));
      send_score(s, i == n - 1, act);
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk iff pending == 0);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    k_model = 4'd4;
    sent_count = 0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset K, extremes, ties, short rows, inactive rows
    send_score(16'sh7fff, 0, 1);
    send_score(-16'sh8000, 0, 1);
    send_score(16'sh7fff, 0, 1);
    send_score(16'sh0000, 1, 1);
    send_score(16'sh0100, 1, 1);
    send_score(16'sh0500, 0, 0);
    send_score(16'sh0600, 1, 0);
    send_score(16'sh0000, 0, 1);
    send_score(16'sh1000, 0, 0);
    send_score(16'sh0000, 1, 0);
    send_score(-16'sh0001, 0, 1);
    send_score(16'sh0000, 1, 1);
    drain();
    write_top_count(4'd8);
    send_row(10, 300, 1);
    send_row(3, 0, 1);
    drain();
    write_top_count(4'd0);
    send_row(4, 0, 1);
    drain();
    write_top_count(4'd15);
    send_row(9, 4000, 1);
    drain();
    write_top_count(4'd1);
    send_row(2, 0, 1);
    drain();

    // random rows under several K settings
    while (sent_count < 150) begin
      write_top_count(4'($urandom_range(0, 15)));
      repeat ($urandom_range(2, 5)) begin
        int kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) send_row($urandom_range(1, 6), 0, 0);
        else send_row($urandom_range(1, 12), (kind < 5) ? 600 : 0, 1);
      end
      drain();
    end

    $display("covered %0d requests, %0d rows, %0d results", sent_count, rows_done,
             results_seen);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // run limit
  initial begin
    #8000000;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tss_pkg.sv
rtl/core/tss_div.sv
rtl/core/topk_select_softmax.sv
sim/topk_checker.sv
sim/tb.sv
